// ===== design/sdpd_pkg.sv =====
// ----------------------------------------------------------------------------
// sdpd_pkg: shared types and constants of the pulse detector
// Holds register indexes, reset values, window limits and the field layout
// of a delay-line memory word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdpd_pkg;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_LOG2_WINDOW      = 1'b0,
        CFG_ENERGY_THRESHOLD = 1'b1
    } cfg_index_t;

    localparam int CFG_DATA_W = 16;

    // Window length limits, as log2 of L
    localparam int LOG2_LO = 1;
    localparam int LOG2_HI = 9;

    localparam logic [3:0]  LOG2_WINDOW_RESET = 4'd5;
    localparam logic [15:0] THRESHOLD_RESET   = 16'd7000;

    // Largest energy value reported
    localparam int ENERGY_MAX = 65535;
    localparam int ENERGY_W   = 17;
    localparam int STAMP_W    = 32;

    // Fields of one delay-line word; a read one window back yields each
    // field delayed by L, i.e. the next field of the chain.
    localparam int TAP_X  = 0;
    localparam int TAP_D1 = 1;
    localparam int TAP_D2 = 2;
    localparam int TAP_E0 = 3;
    localparam int TAP_E1 = 4;
    localparam int TAPS   = 5;

endpackage

// ===== design/second_derivative_pulse_detector_core.sv =====
// ----------------------------------------------------------------------------
// second_derivative_pulse_detector_core: box-filter 2nd-derivative detector
// Pipeline: a sample beat passes stage 1, stage 2 and the output register.
// Throughput: one sample per cycle unless a result held by out_ready stalls it;
// the delay-line memories take one read and one write each per cycle, which sets that figure.
// Reset: clears counters, running sums and pipeline valids; the registers
// return to log2_window = 5 and energy_threshold = 7000. Memory is not
// cleared: entries older than the current record are masked to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module second_derivative_pulse_detector_core #(
    parameter int MAX_WINDOW  = 512,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // sample channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [SAMPLE_BITS-1:0]        sample,
    input  logic                                 record_start,

    // result channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [sdpd_pkg::ENERGY_W-1:0] energy,
    output logic [sdpd_pkg::STAMP_W-1:0]         timestamp,

    // configuration write port
    input  logic                                 cfg_we,
    input  logic [0:0]                           cfg_index,
    input  logic [sdpd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // ------------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------------
    localparam int SW         = SAMPLE_BITS;
    localparam int FLOOR_LOG2 = $clog2(MAX_WINDOW + 1) - 1;
    // Largest usable log2 of L: limited by the register range and memory depth
    localparam int LOG2_CAP   = (FLOOR_LOG2 < sdpd_pkg::LOG2_HI) ? FLOOR_LOG2
                                                                : sdpd_pkg::LOG2_HI;
    localparam int LGW        = $clog2(LOG2_CAP + 1);
    localparam int LEN_W      = LOG2_CAP + 1;
    localparam int AW         = (MAX_WINDOW > 2) ? $clog2(MAX_WINDOW) : 1;
    localparam int FILL_CAP   = 4 * MAX_WINDOW;
    localparam int FW         = $clog2(FILL_CAP + 1);
    localparam int SUM_W      = SW + LOG2_CAP + 1;
    localparam int DW         = SW + LOG2_CAP + 3;
    localparam int DIFF_W     = SUM_W + 1;
    localparam int EW         = (DIFF_W + 1 > 18) ? DIFF_W + 1 : 18;
    localparam int TW         = sdpd_pkg::STAMP_W;

    localparam logic [AW-1:0] PTR_LAST = AW'(MAX_WINDOW - 1);
    localparam logic [FW-1:0] FILL_TOP = FW'(FILL_CAP);
    localparam logic signed [EW-1:0] E_MAX = EW'(sdpd_pkg::ENERGY_MAX);

    typedef logic [sdpd_pkg::TAPS-1:0][SW-1:0] word_t;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [3:0]  log2_reg;
    logic [15:0] thr_reg;
    logic        cfg_restart;

    assign cfg_restart = cfg_we && (cfg_index == sdpd_pkg::CFG_LOG2_WINDOW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_reg <= sdpd_pkg::LOG2_WINDOW_RESET;
            thr_reg  <= sdpd_pkg::THRESHOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sdpd_pkg::CFG_LOG2_WINDOW:      log2_reg <= cfg_data[3:0];
                sdpd_pkg::CFG_ENERGY_THRESHOLD: thr_reg  <= cfg_data[15:0];
                default:                        ;
            endcase
        end
    end

    // Effective window: clamp the register to the supported range
    logic [3:0]       lg_clamp;
    logic [LGW-1:0]   lg;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] half;

    always_comb
    begin
        if (log2_reg < 4'(sdpd_pkg::LOG2_LO))
            lg_clamp = 4'(sdpd_pkg::LOG2_LO);
        else if (log2_reg > 4'(LOG2_CAP))
            lg_clamp = 4'(LOG2_CAP);
        else
            lg_clamp = log2_reg;
        lg   = LGW'(lg_clamp);
        len  = LEN_W'(1) << lg;
        half = len >> 1;
    end

    // Sample ages in fill-count width, for masking stale history
    logic [FW-1:0] age_len, age_2len, age_3len, age_h1, age_lh1, age_2lh1;

    always_comb
    begin
        age_len  = FW'(len);
        age_2len = FW'(len) + FW'(len);
        age_3len = age_2len + FW'(len);
        age_h1   = FW'(half) + FW'(1);
        age_lh1  = age_len + age_h1;
        age_2lh1 = age_2len + age_h1;
    end

    // ------------------------------------------------------------------------
    // Handshake and pipeline advance
    // ------------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic s2_hit, out_free, s2_free, s1_free, s1_adv, accept;

    assign out_free = !out_valid_reg || out_ready;
    assign s2_free  = !s2_valid_reg || !s2_hit || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign in_ready = s1_free;
    assign accept   = in_valid && in_ready;

    // ------------------------------------------------------------------------
    // Stage 0: accept a beat, advance pointer and counters, issue reads
    // ------------------------------------------------------------------------
    logic [AW-1:0]  ptr_reg, ptr_next;
    logic [FW-1:0]  fill_reg, fill_base, fill_next;
    logic [TW-1:0]  count_reg, count_base;
    logic [AW-1:0]  rd1_addr, rd2_addr;
    logic [AW:0]    age1, age2;

    // Address of the entry written 'age' beats before the one at 'p'
    function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] p,
                                                input logic [AW:0]   age);
        logic [AW:0] pe;
        begin
            pe = {1'b0, p};
            if (pe >= age)
                back_addr = AW'(pe - age);
            else
                back_addr = AW'(pe + (AW + 1)'(MAX_WINDOW) - age);
        end
    endfunction

    always_comb
    begin
        ptr_next   = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + AW'(1);
        fill_base  = record_start ? '0 : fill_reg;
        fill_next  = (fill_base < FILL_TOP) ? fill_base + FW'(1) : fill_base;
        count_base = record_start ? '0 : count_reg;
        age1       = (AW + 1)'(len);
        age2       = (AW + 1)'(half) + (AW + 1)'(1);
        rd1_addr   = back_addr(ptr_next, age1);
        rd2_addr   = back_addr(ptr_next, age2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            fill_reg  <= '0;
            count_reg <= '0;
        end
        else if (cfg_restart)
        begin
            fill_reg  <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            ptr_reg   <= ptr_next;
            fill_reg  <= fill_next;
            count_reg <= count_base + TW'(1);
        end
    end

    // Stage 1 holding registers
    logic signed [SW-1:0] s1_x_reg;
    logic [AW-1:0]        s1_ptr_reg;
    logic [FW-1:0]        s1_fill_reg;
    logic [TW-1:0]        s1_count_reg;
    logic                 s1_restart_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_free)
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg       <= sample;
            s1_ptr_reg     <= ptr_next;
            s1_fill_reg    <= fill_next;
            s1_count_reg   <= count_base;
            s1_restart_reg <= record_start;
        end
    end

    // ------------------------------------------------------------------------
    // Delay-line memories
    // mem1 holds the chain {x, d1, d2, e0, e1}; reading one window back gives
    // {d1, d2, d3, e1, e2}. mem2 holds raw samples for the half-window tap e0.
    // A read only happens on accept, so the read data holds through stalls.
    // The entry written in the same cycle is always the previous beat, and
    // both read ages are at least two, so reads never hit the write address.
    // ------------------------------------------------------------------------
    word_t          mem1 [MAX_WINDOW];
    logic [SW-1:0]  mem2 [MAX_WINDOW];
    word_t          m1_rd_reg;
    logic [SW-1:0]  m2_rd_reg;
    word_t          wr_word;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m1_rd_reg <= mem1[rd1_addr];
            m2_rd_reg <= mem2[rd2_addr];
        end
        if (s1_adv)
        begin
            mem1[s1_ptr_reg] <= wr_word;
            mem2[s1_ptr_reg] <= s1_x_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: mask stale taps, update derivative and window sums
    // ------------------------------------------------------------------------
    logic signed [DW-1:0]    deriv_reg, deriv_base, deriv_next;
    logic signed [SUM_W-1:0] lead_reg, lag_reg, lead_base, lag_base;
    logic signed [SUM_W-1:0] lead_next, lag_next;
    logic                    dvalid_reg, dvalid_next;
    logic signed [SW-1:0]    d1, d2, d3, e0, e1, e2;
    logic signed [DW-1:0]    t_x, t_d1, t_d2, t_d3;
    logic                    s1_cross;

    always_comb
    begin
        // Drop taps older than the current record
        d1 = (s1_fill_reg > age_len)  ? m1_rd_reg[sdpd_pkg::TAP_X]  : '0;
        d2 = (s1_fill_reg > age_2len) ? m1_rd_reg[sdpd_pkg::TAP_D1] : '0;
        d3 = (s1_fill_reg > age_3len) ? m1_rd_reg[sdpd_pkg::TAP_D2] : '0;
        e0 = (s1_fill_reg > age_h1)   ? m2_rd_reg                   : '0;
        e1 = (s1_fill_reg > age_lh1)  ? m1_rd_reg[sdpd_pkg::TAP_E0] : '0;
        e2 = (s1_fill_reg > age_2lh1) ? m1_rd_reg[sdpd_pkg::TAP_E1] : '0;

        wr_word[sdpd_pkg::TAP_X]  = s1_x_reg;
        wr_word[sdpd_pkg::TAP_D1] = d1;
        wr_word[sdpd_pkg::TAP_D2] = d2;
        wr_word[sdpd_pkg::TAP_E0] = e0;
        wr_word[sdpd_pkg::TAP_E1] = e1;

        deriv_base = s1_restart_reg ? '0 : deriv_reg;
        lead_base  = s1_restart_reg ? '0 : lead_reg;
        lag_base   = s1_restart_reg ? '0 : lag_reg;

        t_x  = DW'(s1_x_reg);
        t_d1 = DW'(d1);
        t_d2 = DW'(d2);
        t_d3 = DW'(d3);

        // s(t+1) = s(t) + x[n] - 3 d1 + 3 d2 - d3
        deriv_next = deriv_base + t_x - (t_d1 + t_d1 + t_d1)
                   + (t_d2 + t_d2 + t_d2) - t_d3;
        lead_next  = lead_base + SUM_W'(e0) - SUM_W'(e1);
        lag_next   = lag_base + SUM_W'(e1) - SUM_W'(e2);
        dvalid_next = (s1_fill_reg >= age_3len);

        // Falling zero crossing of the derivative
        s1_cross = !s1_restart_reg && dvalid_reg && !deriv_reg[DW-1]
                 && deriv_next[DW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deriv_reg  <= '0;
            lead_reg   <= '0;
            lag_reg    <= '0;
            dvalid_reg <= 1'b0;
        end
        else if (cfg_restart)
        begin
            deriv_reg  <= '0;
            lead_reg   <= '0;
            lag_reg    <= '0;
            dvalid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            deriv_reg  <= deriv_next;
            lead_reg   <= lead_next;
            lag_reg    <= lag_next;
            dvalid_reg <= dvalid_next;
        end
    end

    // Stage 2 holding registers
    logic                    s2_cross_reg;
    logic signed [SUM_W-1:0] s2_lead_reg, s2_lag_reg;
    logic [TW-1:0]           s2_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_free)
            s2_valid_reg <= s1_adv;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_cross_reg <= s1_cross;
            s2_lead_reg  <= lead_next;
            s2_lag_reg   <= lag_next;
            s2_count_reg <= s1_count_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: energy = (lead - lag) / L toward zero, threshold, saturate
    // ------------------------------------------------------------------------
    logic signed [DIFF_W-1:0] diff;
    logic signed [EW-1:0]     diff_ext, bias, quot, thr_ext, e_sat;
    logic [TW-1:0]            stamp;

    always_comb
    begin
        diff     = DIFF_W'(s2_lead_reg) - DIFF_W'(s2_lag_reg);
        diff_ext = EW'(diff);
        // Round toward zero: bias negative values by L-1 before the shift
        bias     = diff[DIFF_W-1] ? $signed(EW'(len) - EW'(1)) : '0;
        quot     = (diff_ext + bias) >>> lg;
        thr_ext  = $signed(EW'(thr_reg));
        s2_hit   = s2_valid_reg && s2_cross_reg && (quot >= thr_ext);
        e_sat    = (quot > E_MAX) ? E_MAX : quot;
        stamp    = s2_count_reg - (TW'(len) + TW'(len) + TW'(len));
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    logic signed [sdpd_pkg::ENERGY_W-1:0] energy_reg;
    logic [TW-1:0]                        stamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_hit && out_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_hit && out_free)
        begin
            energy_reg <= sdpd_pkg::ENERGY_W'(e_sat);
            stamp_reg  <= stamp;
        end
    end

    assign out_valid = out_valid_reg;
    assign energy    = energy_reg;
    assign timestamp = stamp_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // A reported energy passed a non-negative threshold
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !energy_reg[sdpd_pkg::ENERGY_W-1])
        else $error("negative energy reported");

    // Fill count saturates at the history span
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_TOP)
        else $error("fill count overran its cap");

    // A window-back read never lands on the entry written in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_adv) |-> (rd1_addr != s1_ptr_reg && rd2_addr != s1_ptr_reg))
        else $error("delay-line read collides with write");

endmodule
